/* src/esc_pkg.sv */
package esc_pkg;

   localparam int unsigned InWidth   = 32;
   localparam int unsigned OutWidth  = 40;

   localparam int unsigned YearWidth = 12;
   localparam int unsigned MonWidth  = 4;
   localparam int unsigned DayWidth  = 5;
   localparam int unsigned HourWidth = 5;
   localparam int unsigned MinWidth  = 6;
   localparam int unsigned SecWidth  = 6;

   localparam int unsigned DaysWidth = 16;  // 2^32 / 86400 < 49711
   localparam int unsigned TodWidth  = 17;  // < 86400
   localparam int unsigned QuadWidth = 6;   // < 35
   localparam int unsigned RemWidth  = 11;  // < 1461
   localparam int unsigned DoyWidth  = 9;   // < 366
   localparam int unsigned RemhWidth = 12;  // < 3600

   localparam logic [31:0] SecsPerDay  = 32'd86400;
   localparam logic [16:0] SecsPerHour = 17'd3600;
   localparam logic [11:0] SecsPerMin  = 12'd60;
   localparam logic [15:0] DaysPerQuad = 16'd1461;
   localparam logic [11:0] FirstYear   = 12'd1970;
   localparam logic [11:0] LastYear    = 12'd2099;
   localparam int unsigned NumMonthSteps = 11;

   // exact reciprocals: floor(x / d) = (x * ceil(2^k / d)) >> k over the input range
   localparam logic [25:0] RecipDay  = 26'd50903317;  // 1/675, k = 35 (after >> 7)
   localparam int unsigned ShiftDay  = 35;
   localparam logic [16:0] RecipQuad = 17'd91868;     // 1/1461, k = 27
   localparam int unsigned ShiftQuad = 27;
   localparam logic [17:0] RecipHour = 18'd149131;    // 1/3600, k = 29
   localparam int unsigned ShiftHour = 29;
   localparam logic [12:0] RecipMin  = 13'd4370;      // 1/60, k = 18
   localparam int unsigned ShiftMin  = 18;

   // first day of year of each month, index 0 = January
   function automatic logic [DoyWidth-1:0] month_start(input logic [MonWidth-1:0] mon,
                                                       input logic leap);
      logic [DoyWidth-1:0] base;
      begin
         unique case (mon)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
         endcase
         if (leap && mon >= 4'd2) begin
            base = base + 9'd1;
         end
         return base;
      end
   endfunction

endpackage

/* src/epoch_seconds_to_calendar_unit.sv */
// Epoch seconds to calendar converter.
//
// Input stream (req_*): one transfer carries an unsigned 32-bit count of
// seconds since midnight 1 Jan 1970. Output stream (rsp_*): one transfer per
// input with year, month, day of month, hour, minute and second in
// rsp_tdata and the valid flag in rsp_tuser. Dates past 2099 give a zero
// payload with the flag low.
//
// Timing: seven register stages, the last one the output register. One
// item is taken per cycle while the output is not stalled. The stage
// count follows the chain of constant-reciprocal multiplies (day split,
// four-year split, hour split, minute split), each followed by a register.
//
// Reset clears all stage valid bits; the pipeline comes up empty.
// When the receiver holds rsp_tready low with a result waiting, the whole
// pipeline freezes and req_tready drops; nothing is lost or repeated.
module epoch_seconds_to_calendar_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [esc_pkg::InWidth-1:0]     req_tdata,   // [31:0] epoch_seconds
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [11:0] year, [15:12] month, [20:16] day_of_month, [25:21] hour,
   // [31:26] minute, [37:32] second, [39:38] zero
   output logic [esc_pkg::OutWidth-1:0]    rsp_tdata,
   output logic                            rsp_tuser    // [0] valid_res
);
   import esc_pkg::*;

   logic adv;
   logic [6:0] vld_ff;

   // stage 1
   logic [50:0] p1_in, p1_ff;
   logic [31:0] t1_ff;
   // stage 2
   logic [DaysWidth-1:0] days2_in, days2_ff;
   logic [31:0] t2_ff;
   // stage 3
   logic [TodWidth-1:0]  tod3_in, tod3_ff;
   logic [32:0]          p2_in, p2_ff;
   logic [DaysWidth-1:0] days3_ff;
   // stage 4
   logic [QuadWidth-1:0] quad4_in, quad4_ff;
   logic [RemWidth-1:0]  rem4_in, rem4_ff;
   logic [34:0]          p3_in, p3_ff;
   logic [TodWidth-1:0]  tod4_ff;
   // stage 5
   logic [YearWidth-1:0] year5_in, year5_ff;
   logic [DoyWidth-1:0]  doy5_in, doy5_ff;
   logic                 leap5_in, leap5_ff;
   logic                 ok5_in, ok5_ff;
   logic [HourWidth-1:0] hour5_in, hour5_ff;
   logic [RemhWidth-1:0] remh5_in, remh5_ff;
   logic [YearWidth-1:0] year_base;
   // stage 6
   logic [MonWidth-1:0]  mon6_in, mon6_ff;
   logic [DayWidth-1:0]  day6_in, day6_ff;
   logic [24:0]          p4_in, p4_ff;
   logic [YearWidth-1:0] year6_ff;
   logic                 ok6_ff;
   logic [HourWidth-1:0] hour6_ff;
   logic [RemhWidth-1:0] remh6_ff;
   logic [DoyWidth-1:0]  day_off;
   // stage 7 (output register)
   logic [OutWidth-1:0]  out_in, out_ff;
   logic                 ok7_ff;
   logic [MinWidth-1:0]  minute;
   logic [SecWidth-1:0]  second;

   assign adv        = !vld_ff[6] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[6];
   assign rsp_tdata  = out_ff;
   assign rsp_tuser  = ok7_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[5:0], req_tvalid};
      end
   end

   // 86400 = 128 * 675
   assign p1_in = 51'(req_tdata[31:7]) * 51'(RecipDay);

   assign days2_in = p1_ff[ShiftDay +: DaysWidth];

   assign tod3_in = TodWidth'(t2_ff - 32'(days2_ff) * SecsPerDay);
   assign p2_in   = 33'(days2_ff) * 33'(RecipQuad);

   assign quad4_in = p2_ff[ShiftQuad +: QuadWidth];
   assign rem4_in  = RemWidth'(days3_ff - 16'(quad4_in) * DaysPerQuad);
   assign p3_in    = 35'(tod3_ff) * 35'(RecipHour);

   // four-year period: 365, 365, 366, 365 days
   assign year_base = FirstYear + {4'd0, quad4_ff, 2'b00};
   always_comb begin
      leap5_in = 1'b0;
      priority if (rem4_ff >= 11'd1096) begin
         year5_in = year_base + 12'd3;
         doy5_in  = DoyWidth'(rem4_ff - 11'd1096);
      end else if (rem4_ff >= 11'd730) begin
         year5_in = year_base + 12'd2;
         doy5_in  = DoyWidth'(rem4_ff - 11'd730);
         leap5_in = 1'b1;
      end else if (rem4_ff >= 11'd365) begin
         year5_in = year_base + 12'd1;
         doy5_in  = DoyWidth'(rem4_ff - 11'd365);
      end else begin
         year5_in = year_base;
         doy5_in  = DoyWidth'(rem4_ff);
      end
   end
   assign ok5_in   = year5_in <= LastYear;
   assign hour5_in = p3_ff[ShiftHour +: HourWidth];
   assign remh5_in = RemhWidth'(tod4_ff - 17'(hour5_in) * SecsPerHour);

   // month: number of month starts (Feb..Dec) at or before the day of year
   always_comb begin
      mon6_in = '0;
      for (int k = 1; k <= NumMonthSteps; k++) begin
         if (doy5_ff >= month_start(MonWidth'(k), leap5_ff)) begin
            mon6_in = mon6_in + 4'd1;
         end
      end
   end
   assign day_off = doy5_ff - month_start(mon6_in, leap5_ff);
   assign day6_in = DayWidth'(day_off) + 5'd1;
   assign p4_in   = 25'(remh5_ff) * 25'(RecipMin);

   assign minute = p4_ff[ShiftMin +: MinWidth];
   assign second = SecWidth'(remh6_ff - 12'(minute) * SecsPerMin);
   assign out_in = ok6_ff ? {2'b00, second, minute, hour6_ff, day6_ff, mon6_ff + 4'd1, year6_ff}
                          : '0;

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_ff    <= p1_in;
         t1_ff    <= req_tdata;
         days2_ff <= days2_in;
         t2_ff    <= t1_ff;
         tod3_ff  <= tod3_in;
         p2_ff    <= p2_in;
         days3_ff <= days2_ff;
         quad4_ff <= quad4_in;
         rem4_ff  <= rem4_in;
         p3_ff    <= p3_in;
         tod4_ff  <= tod3_ff;
         year5_ff <= year5_in;
         doy5_ff  <= doy5_in;
         leap5_ff <= leap5_in;
         ok5_ff   <= ok5_in;
         hour5_ff <= hour5_in;
         remh5_ff <= remh5_in;
         mon6_ff  <= mon6_in;
         day6_ff  <= day6_in;
         p4_ff    <= p4_in;
         year6_ff <= year5_ff;
         ok6_ff   <= ok5_ff;
         hour6_ff <= hour5_ff;
         remh6_ff <= remh5_ff;
         out_ff   <= out_in;
         ok7_ff   <= ok6_ff;
      end
   end

endmodule

/* tb/tb_epoch_seconds_to_calendar_unit.sv */
module tb_epoch_seconds_to_calendar_unit;

   localparam int unsigned DaySecs   = 86400;
   localparam int unsigned HourSecs  = 3600;
   localparam int unsigned MinSecs   = 60;
   localparam int unsigned QuadDays  = 1461;
   localparam int unsigned EpochYear = 1970;
   localparam int unsigned FinalYear = 2099;
   localparam int unsigned LastGoodDay = 47481;              // 2099-12-31
   localparam logic [31:0] FirstBadStamp = 32'd4102444800;  // 2100-01-01 00:00:00
   localparam int unsigned Latency   = 7;
   localparam int unsigned MaxGap    = 40;
   localparam int unsigned MaxReports = 10;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  mday;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  sec;
      logic        ok;
   } cal_t;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [esc_pkg::InWidth-1:0]   req_tdata = '0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [esc_pkg::OutWidth-1:0]  rsp_tdata;
   logic                          rsp_tuser;

   cal_t        pending_dates[$];
   logic [31:0] pending_stamps[$];
   int unsigned bad_dates = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned hold_left = 0;

   epoch_seconds_to_calendar_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Four-year cycle with the leap year third; out-of-range years give all zeros.
   function automatic cal_t to_calendar(input logic [31:0] stamp);
      int unsigned t;
      int unsigned days;
      int unsigned tod;
      int unsigned rem;
      int unsigned yr;
      int unsigned mon;
      bit          leap;
      int unsigned mlen [12];
      cal_t        c;
      t    = stamp;
      c    = '0;
      mlen = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      days = t / DaySecs;
      tod  = t % DaySecs;
      rem  = days % QuadDays;
      yr   = EpochYear + (days / QuadDays) * 4;
      leap = 1'b0;
      if (rem >= 365) begin
         yr++;
         rem -= 365;
         if (rem >= 365) begin
            yr++;
            rem -= 365;
            if (rem >= 366) begin
               yr++;
               rem -= 366;
            end else begin
               leap = 1'b1;
            end
         end
      end
      if (yr > FinalYear) begin
         return c;
      end
      if (leap) begin
         mlen[1] = 29;
      end
      // walk stops at December, whatever is left stays there
      mon = 0;
      while (mon < 11 && rem >= mlen[mon]) begin
         rem -= mlen[mon];
         mon++;
      end
      c.year   = yr[11:0];
      c.month  = 4'(mon + 1);
      c.mday   = 5'(rem + 1);
      c.hour   = 5'(tod / HourSecs);
      c.minute = 6'((tod % HourSecs) / MinSecs);
      c.sec    = 6'(tod % MinSecs);
      c.ok     = 1'b1;
      return c;
   endfunction

   // Returns at the rising edge of the transfer; valid stays up for the next call.
   task automatic send_stamp(input logic [31:0] stamp);
      int unsigned gap;
      gap = 0;
      while (gap < MaxGap && $urandom_range(99) < send_idle_pct) begin
         gap++;
      end
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= stamp;
      do begin
         @(posedge clock);
      end while (!req_tready);
      pending_dates.push_back(to_calendar(stamp));
      pending_stamps.push_back(stamp);
   endtask

   task automatic wait_all_dates();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_dates.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic test_directed();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_stamp(32'd0);
      send_stamp(32'd1);
      send_stamp(32'd59);
      send_stamp(32'd60);
      send_stamp(32'd3599);
      send_stamp(32'd3600);
      send_stamp(32'd86399);
      send_stamp(32'd86400);
      send_stamp(32'(364 * DaySecs + 86399));   // 1970-12-31 23:59:59
      send_stamp(32'(789 * DaySecs));           // 1972-02-29, leap day
      send_stamp(32'(790 * DaySecs));           // 1972-03-01
      send_stamp(32'(1095 * DaySecs + 86399));  // Dec 31 of a leap year
      send_stamp(32'(1096 * DaySecs));          // 1973-01-01
      send_stamp(32'(423 * DaySecs));           // 1971-02-28 -> next day is March
      send_stamp(32'(424 * DaySecs));
      send_stamp(32'h8000_0000);
      send_stamp(32'hAAAA_AAAA);
      send_stamp(32'h5555_5555);
      send_stamp(FirstBadStamp - 32'd1);        // last second of 2099
      send_stamp(FirstBadStamp);
      send_stamp(32'hFFFF_FFFF);
      wait_all_dates();
   endtask

   task automatic test_random_stamps(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input int unsigned count);
      logic [31:0] stamp;
      int unsigned d;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (count) begin
         case ($urandom_range(9))
            0, 1, 2, 3, 4: stamp = $urandom_range(FirstBadStamp - 32'd1, 0);
            5, 6: begin
               // hug a midnight so day, month and year rollovers come often
               d = $urandom_range(LastGoodDay);
               stamp = d * DaySecs + ($urandom_range(1) ? $urandom_range(2)
                                                         : DaySecs - 1 - $urandom_range(2));
            end
            7: stamp = $urandom();
            8: stamp = $urandom_range(32'hFFFF_FFFF, FirstBadStamp);
            default: stamp = FirstBadStamp - 32'd50000 + $urandom_range(100000);
         endcase
         send_stamp(stamp);
      end
      wait_all_dates();
   endtask

   task automatic test_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_stamp($urandom_range(FirstBadStamp - 32'd1, 0));
      // receiver holds off while the sender keeps offering; input must stall
      hold_left = 200;
      repeat (63) begin
         send_stamp($urandom());
      end
      wait_all_dates();
   endtask

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cal_t        got;
      cal_t        want;
      logic [31:0] stamp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.year   = rsp_tdata[11:0];
         got.month  = rsp_tdata[15:12];
         got.mday   = rsp_tdata[20:16];
         got.hour   = rsp_tdata[25:21];
         got.minute = rsp_tdata[31:26];
         got.sec    = rsp_tdata[37:32];
         got.ok     = rsp_tuser;
         if (pending_dates.size() == 0) begin
            bad_dates++;
            if (bad_dates <= MaxReports) begin
               $display("unexpected transfer: %0d-%0d-%0d %0d:%0d:%0d valid %0b",
                        got.year, got.month, got.mday, got.hour, got.minute, got.sec,
                        got.ok);
            end
         end else begin
            want  = pending_dates.pop_front();
            stamp = pending_stamps.pop_front();
            if (got !== want) begin
               bad_dates++;
               if (bad_dates <= MaxReports) begin
                  $display("stamp %0d: expected %0d-%0d-%0d %0d:%0d:%0d valid %0b, %s",
                           stamp, want.year, want.month, want.mday, want.hour,
                           want.minute, want.sec, want.ok, "got:");
                  $display("   got %0d-%0d-%0d %0d:%0d:%0d valid %0b",
                           got.year, got.month, got.mday, got.hour, got.minute, got.sec,
                           got.ok);
               end
            end
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_stamps(0, 0, 420);
      test_random_stamps(52, 0, 420);
      test_random_stamps(0, 52, 420);
      test_random_stamps(20, 20, 420);
      test_backpressure();
      repeat (Latency * 3) @(posedge clock);
      if (bad_dates == 0 && pending_dates.size() == 0) begin
         $display("epoch_seconds_to_calendar_unit: match");
      end else begin
         $display("epoch_seconds_to_calendar_unit: mismatch");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("epoch_seconds_to_calendar_unit: mismatch");
      $finish;
   end

endmodule

/* sim.f */
src/esc_pkg.sv
src/epoch_seconds_to_calendar_unit.sv
tb/tb_epoch_seconds_to_calendar_unit.sv
